### design/ccs_pkg.sv
package ccs_pkg;

	// Grid limits
	localparam int MAX_RADIAL_DEF = 64;
	localparam int MAX_AXIAL_DEF  = 64;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int REG_W  = 7;
	localparam logic REG_RADIAL = 1'b0;
	localparam logic REG_AXIAL  = 1'b1;
	localparam logic [REG_W-1:0] POINTS_RESET = 7'd64;

	// Shared divider widths
	localparam int DIV_NW = 65;
	localparam int DIV_DW = 33;

	// Result status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_SAT  = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOAD_R = 2'd0,
		MODE_LOAD_Z = 2'd1,
		MODE_LOAD_F = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_DPHIDZ = 3'd0,
		OP_DRDZ   = 3'd1,
		OP_DZDR   = 3'd2,
		OP_DRPHI  = 3'd3,
		OP_CURLZ  = 3'd4
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_A0,
		ST_A1,
		ST_A2,
		ST_A3,
		ST_C3,
		ST_DIFF,
		ST_MUL2,
		ST_NDIFF,
		ST_DGO,
		ST_DWAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic [1:0] rd_sel;
		logic cap_en;
		logic [1:0] cap_sel;
		logic diff_en;
		logic mul_en;
		logic mul_lo;
		logic zchk_en;
		logic ndiff_en;
		logic div_start;
		div_op_t div_op;
		logic div_store;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic zero_div;
		logic div_done;
	} stat_t;

	// Saturate to 32 bits; top bit flags saturation
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -66'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

### design/cylindrical_curl_stencil_top.sv
// Axisymmetric curl on a cylindrical (R, Z) grid in signed Q16.16. Load words
// (radial coordinate, axial coordinate, field sample) are taken in the cycle
// start is seen with busy low and never raise busy, so one can follow every
// cycle. A query word raises busy while it steps through a range check, four fetch
// steps from single-port tables, differences and two 32x32 products, then five
// divisions in turn through one shared divider that forms one quotient bit a
// cycle (65 bits each, with its start and hand-off). A zero step or
// a zero radius skips the divisions and goes straight to the result. A query
// outside the points in use holds busy for one cycle and returns nothing. The
// result is shown for exactly one cycle with done high, in the first cycle that
// busy is low again; the receiver cannot stall, so it must take it then. Tables come
// up undefined and must be written before they are read.
module cylindrical_curl_stencil_top import ccs_pkg::*; #(
	parameter int MAX_RADIAL = MAX_RADIAL_DEF,
	parameter int MAX_AXIAL  = MAX_AXIAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [5:0]         radial_index,
	input  logic [5:0]         axial_index,
	input  logic signed [31:0] coordinate,
	input  logic signed [31:0] field_r,
	input  logic signed [31:0] field_z,
	input  logic signed [31:0] field_phi,
	output logic               done,
	output logic signed [31:0] curl_r,
	output logic signed [31:0] curl_z,
	output logic signed [31:0] curl_phi,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;

	ccs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ccs_dp #(
		.MAX_RADIAL (MAX_RADIAL),
		.MAX_AXIAL  (MAX_AXIAL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.radial_index (radial_index),
		.axial_index  (axial_index),
		.coordinate   (coordinate),
		.field_r      (field_r),
		.field_z      (field_z),
		.field_phi    (field_phi),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.done         (done),
		.curl_r       (curl_r),
		.curl_z       (curl_z),
		.curl_phi     (curl_phi),
		.status       (status)
	);

endmodule

### design/ccs_div.sv
module ccs_div import ccs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIV_NW-1:0] num,
	input  logic signed [DIV_DW-1:0] den,
	output logic                     done,
	output logic signed [DIV_NW-1:0] quo
);

	logic              run_q;
	logic [6:0]        cnt_q;
	logic [DIV_NW-1:0] acc_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dmag_q;
	logic              neg_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              qbit;

	// Form one quotient bit by trial subtraction
	always_comb begin
		trial = {rem_q, acc_q[DIV_NW-1]};
		qbit  = (trial >= {1'b0, dmag_q});
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= num[DIV_NW-1] ? DIV_NW'(-num) : num;
			dmag_q <= den[DIV_DW-1] ? DIV_DW'(-den) : den;
			rem_q  <= '0;
			neg_q  <= num[DIV_NW-1] ^ den[DIV_DW-1];
		end else if (run_q) begin
			rem_q <= qbit ? DIV_DW'(trial - {1'b0, dmag_q}) : trial[DIV_DW-1:0];
			acc_q <= {acc_q[DIV_NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? DIV_NW'(-$signed(acc_q)) : $signed(acc_q);

endmodule

### design/ccs_dp.sv
module ccs_dp import ccs_pkg::*; #(
	parameter int MAX_RADIAL = MAX_RADIAL_DEF,
	parameter int MAX_AXIAL  = MAX_AXIAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         mode,
	input  logic [5:0]         radial_index,
	input  logic [5:0]         axial_index,
	input  logic signed [31:0] coordinate,
	input  logic signed [31:0] field_r,
	input  logic signed [31:0] field_z,
	input  logic signed [31:0] field_phi,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               done,
	output logic signed [31:0] curl_r,
	output logic signed [31:0] curl_z,
	output logic signed [31:0] curl_phi,
	output logic [1:0]         status
);

	localparam int RW  = (MAX_RADIAL > 1) ? $clog2(MAX_RADIAL) : 1;
	localparam int ZW  = (MAX_AXIAL > 1) ? $clog2(MAX_AXIAL) : 1;
	localparam int AW  = $clog2(MAX_RADIAL * MAX_AXIAL);
	localparam int NRW = ($clog2(MAX_RADIAL + 1) > REG_W) ? $clog2(MAX_RADIAL + 1) : REG_W;
	localparam int NZW = ($clog2(MAX_AXIAL + 1) > REG_W) ? $clog2(MAX_AXIAL + 1) : REG_W;

	logic [REG_W-1:0] rpts_q, zpts_q;
	logic [NRW-1:0] nr, ihi, ilo, iw;
	logic [NZW-1:0] nz, jhi, jlo, jw;
	logic [5:0] i_q, j_q;

	logic [31:0] rad_mem [MAX_RADIAL];
	logic [31:0] ax_mem  [MAX_AXIAL];
	logic [31:0] fr_mem  [MAX_RADIAL * MAX_AXIAL];
	logic [31:0] fz_mem  [MAX_RADIAL * MAX_AXIAL];
	logic [31:0] fp_mem  [MAX_RADIAL * MAX_AXIAL];
	logic [31:0] rad_rd, ax_rd, fr_rd, fz_rd, fp_rd;

	logic [RW-1:0] rad_ra;
	logic [ZW-1:0] ax_ra;
	logic [AW-1:0] f_ra, f_wa;
	logic load_ok_r, load_ok_z;

	logic signed [31:0] rhi_q, rlo_q, ri_q, zhi_q, zlo_q;
	logic signed [31:0] phi_jhi_q, phi_jlo_q, r_jhi_q, r_jlo_q;
	logic signed [31:0] phi_ihi_q, z_ihi_q, phi_ilo_q, z_ilo_q;
	logic signed [32:0] ddz_q, ddr_q, dphi_q, drz_q, dzr_q;
	logic signed [63:0] prod_hi_q, prod_lo_q, mul_out;
	logic signed [31:0] mul_a, mul_b;
	logic signed [64:0] n_q;
	logic zero_q;

	logic signed [DIV_NW-1:0] dnum, dquo;
	logic signed [DIV_DW-1:0] dden;
	logic div_done;
	logic signed [DIV_NW-1:0] q_dphi_q, q_drdz_q, q_dzdr_q, q_curlz_q;
	logic signed [31:0] d_q;
	logic dsat_q;
	logic [32:0] sr, sz, sp, sd;

	logic done_q;
	logic signed [31:0] cr_q, cz_q, cp_q;
	logic [1:0] st_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpts_q <= POINTS_RESET;
			zpts_q <= POINTS_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_RADIAL) begin
				rpts_q <= pwdata[REG_W-1:0];
			end else begin
				zpts_q <= pwdata[REG_W-1:0];
			end
		end
	end
	assign prdata = (paddr[2] == REG_RADIAL) ? 32'(rpts_q) : 32'(zpts_q);

	// Clamp the grid size in use and find the stencil neighbours
	always_comb begin
		if (rpts_q < 7'd2) begin
			nr = NRW'(2);
		end else if (NRW'(rpts_q) > NRW'(MAX_RADIAL)) begin
			nr = NRW'(MAX_RADIAL);
		end else begin
			nr = NRW'(rpts_q);
		end
		if (zpts_q < 7'd2) begin
			nz = NZW'(2);
		end else if (NZW'(zpts_q) > NZW'(MAX_AXIAL)) begin
			nz = NZW'(MAX_AXIAL);
		end else begin
			nz = NZW'(zpts_q);
		end
		iw  = NRW'(i_q);
		jw  = NZW'(j_q);
		ilo = (iw != '0) ? iw - NRW'(1) : iw;
		ihi = ((iw + NRW'(1)) < nr) ? iw + NRW'(1) : iw;
		jlo = (jw != '0) ? jw - NZW'(1) : jw;
		jhi = ((jw + NZW'(1)) < nz) ? jw + NZW'(1) : jw;
	end
	assign stat.in_range = (iw < nr) && (jw < nz);

	// Latch the grid point of the word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			i_q <= radial_index;
			j_q <= axial_index;
		end
	end

	// Pick read addresses for the current fetch step
	always_comb begin
		rad_ra = RW'(iw);
		ax_ra  = ZW'(jhi);
		f_ra   = AW'(iw) * AW'(MAX_AXIAL) + AW'(jhi);
		case (cmd.rd_sel)
			2'd0: begin
				rad_ra = RW'(ihi);
				ax_ra  = ZW'(jhi);
				f_ra   = AW'(iw) * AW'(MAX_AXIAL) + AW'(jhi);
			end
			2'd1: begin
				rad_ra = RW'(ilo);
				ax_ra  = ZW'(jlo);
				f_ra   = AW'(iw) * AW'(MAX_AXIAL) + AW'(jlo);
			end
			2'd2: begin
				rad_ra = RW'(iw);
				f_ra   = AW'(ihi) * AW'(MAX_AXIAL) + AW'(jw);
			end
			default: begin
				f_ra   = AW'(ilo) * AW'(MAX_AXIAL) + AW'(jw);
			end
		endcase
	end

	assign load_ok_r = 32'(radial_index) < 32'(MAX_RADIAL);
	assign load_ok_z = 32'(axial_index) < 32'(MAX_AXIAL);
	assign f_wa = AW'(radial_index) * AW'(MAX_AXIAL) + AW'(axial_index);

	// Coordinate tables
	always_ff @(posedge clk) begin
		if (cmd.accept && mode_t'(mode) == MODE_LOAD_R && load_ok_r) begin
			rad_mem[RW'(radial_index)] <= coordinate;
		end
		rad_rd <= rad_mem[rad_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && mode_t'(mode) == MODE_LOAD_Z && load_ok_z) begin
			ax_mem[ZW'(axial_index)] <= coordinate;
		end
		ax_rd <= ax_mem[ax_ra];
	end

	// Field sample stores
	always_ff @(posedge clk) begin
		if (cmd.accept && mode_t'(mode) == MODE_LOAD_F && load_ok_r && load_ok_z) begin
			fr_mem[f_wa] <= field_r;
			fz_mem[f_wa] <= field_z;
			fp_mem[f_wa] <= field_phi;
		end
		fr_rd <= fr_mem[f_ra];
		fz_rd <= fz_mem[f_ra];
		fp_rd <= fp_mem[f_ra];
	end

	// Capture fetched words
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_sel)
				2'd0: begin
					rhi_q     <= rad_rd;
					zhi_q     <= ax_rd;
					phi_jhi_q <= fp_rd;
					r_jhi_q   <= fr_rd;
				end
				2'd1: begin
					rlo_q     <= rad_rd;
					zlo_q     <= ax_rd;
					phi_jlo_q <= fp_rd;
					r_jlo_q   <= fr_rd;
				end
				2'd2: begin
					ri_q      <= rad_rd;
					phi_ihi_q <= fp_rd;
					z_ihi_q   <= fz_rd;
				end
				default: begin
					phi_ilo_q <= fp_rd;
					z_ilo_q   <= fz_rd;
				end
			endcase
		end
	end

	// Form differences, products of r and phi, and the zero check
	assign mul_a   = cmd.mul_lo ? rlo_q : rhi_q;
	assign mul_b   = cmd.mul_lo ? phi_ilo_q : phi_ihi_q;
	assign mul_out = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			ddz_q  <= 33'(zhi_q) - 33'(zlo_q);
			ddr_q  <= 33'(rhi_q) - 33'(rlo_q);
			dphi_q <= 33'(phi_jhi_q) - 33'(phi_jlo_q);
			drz_q  <= 33'(r_jhi_q) - 33'(r_jlo_q);
			dzr_q  <= 33'(z_ihi_q) - 33'(z_ilo_q);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_lo) begin
				prod_lo_q <= mul_out;
			end else begin
				prod_hi_q <= mul_out;
			end
		end
		if (cmd.zchk_en) begin
			zero_q <= (ddz_q == '0) || (ddr_q == '0) || (ri_q == '0);
		end
		if (cmd.ndiff_en) begin
			n_q <= 65'(prod_hi_q) - 65'(prod_lo_q);
		end
	end
	assign stat.zero_div = zero_q;

	// Select divider operands
	always_comb begin
		dnum = DIV_NW'(dphi_q) <<< 16;
		dden = ddz_q;
		case (cmd.div_op)
			OP_DPHIDZ: begin
				dnum = DIV_NW'(dphi_q) <<< 16;
				dden = ddz_q;
			end
			OP_DRDZ: begin
				dnum = DIV_NW'(drz_q) <<< 16;
				dden = ddz_q;
			end
			OP_DZDR: begin
				dnum = DIV_NW'(dzr_q) <<< 16;
				dden = ddr_q;
			end
			OP_DRPHI: begin
				dnum = n_q;
				dden = ddr_q;
			end
			OP_CURLZ: begin
				dnum = DIV_NW'(d_q) <<< 16;
				dden = DIV_DW'(ri_q);
			end
			default: begin
				dnum = DIV_NW'(dphi_q) <<< 16;
				dden = ddz_q;
			end
		endcase
	end

	ccs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (dquo)
	);
	assign stat.div_done = div_done;

	assign sd = sat32(66'(dquo));

	// Keep quotients
	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_op)
				OP_DPHIDZ: q_dphi_q <= dquo;
				OP_DRDZ:   q_drdz_q <= dquo;
				OP_DZDR:   q_dzdr_q <= dquo;
				OP_DRPHI: begin
					d_q    <= sd[31:0];
					dsat_q <= sd[32];
				end
				OP_CURLZ:  q_curlz_q <= dquo;
				default:   q_dphi_q <= dquo;
			endcase
		end
	end

	// Saturate the three components
	always_comb begin
		sr = sat32(-66'(q_dphi_q));
		sz = sat32(66'(q_curlz_q));
		sp = sat32(66'(q_drdz_q) - 66'(q_dzdr_q));
	end

	// Drive the result word for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (zero_q) begin
				cr_q <= '0;
				cz_q <= '0;
				cp_q <= '0;
				st_q <= STATUS_ZERO;
			end else begin
				cr_q <= sr[31:0];
				cz_q <= sz[31:0];
				cp_q <= sp[31:0];
				st_q <= (sr[32] || sz[32] || sp[32] || dsat_q) ? STATUS_SAT : STATUS_OK;
			end
		end
	end

	assign done     = done_q;
	assign curl_r   = cr_q;
	assign curl_z   = cz_q;
	assign curl_phi = cp_q;
	assign status   = st_q;

endmodule

### design/ccs_ctrl.sv
module ccs_ctrl import ccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy
);

	state_t  state_q, state_d;
	div_op_t op_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start && mode_t'(mode) == MODE_QUERY) state_d = ST_CHK;
			ST_CHK:   state_d = stat.in_range ? ST_A0 : ST_IDLE;
			ST_A0:    state_d = ST_A1;
			ST_A1:    state_d = ST_A2;
			ST_A2:    state_d = ST_A3;
			ST_A3:    state_d = ST_C3;
			ST_C3:    state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_NDIFF;
			ST_NDIFF: state_d = stat.zero_div ? ST_FIN : ST_DGO;
			ST_DGO:   state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (stat.div_done) begin
					state_d = (op_q == OP_CURLZ) ? ST_FIN : ST_DGO;
				end
			end
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_DPHIDZ;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NDIFF) begin
				op_q <= OP_DPHIDZ;
			end else if (state_q == ST_DWAIT && stat.div_done) begin
				case (op_q)
					OP_DPHIDZ: op_q <= OP_DRDZ;
					OP_DRDZ:   op_q <= OP_DZDR;
					OP_DZDR:   op_q <= OP_DRPHI;
					OP_DRPHI:  op_q <= OP_CURLZ;
					default:   op_q <= OP_DPHIDZ;
				endcase
			end
		end
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.div_op = op_q;
		case (state_q)
			ST_IDLE: cmd.accept = start;
			ST_A0:   cmd.rd_sel = 2'd0;
			ST_A1: begin
				cmd.rd_sel  = 2'd1;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd0;
			end
			ST_A2: begin
				cmd.rd_sel  = 2'd2;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd1;
			end
			ST_A3: begin
				cmd.rd_sel  = 2'd3;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd2;
			end
			ST_C3: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd3;
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				cmd.mul_en  = 1'b1;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_lo  = 1'b1;
				cmd.zchk_en = 1'b1;
			end
			ST_NDIFF: cmd.ndiff_en  = 1'b1;
			ST_DGO:   cmd.div_start = 1'b1;
			ST_DWAIT: cmd.div_store = stat.div_done;
			ST_FIN:   cmd.fin = 1'b1;
			default:  cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/ccs_checker.sv
module ccs_checker import ccs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         mode,
	input logic               done,
	input logic signed [31:0] curl_r,
	input logic signed [31:0] curl_z,
	input logic signed [31:0] curl_phi,
	input logic [1:0]         status
);

	// A result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// A result word lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// Status carries a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STATUS_OK || status == STATUS_SAT || status == STATUS_ZERO))
		else $error("undefined status");

	// Zero divisor clears the components
	a_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_ZERO) |-> (curl_r == 0 && curl_z == 0 && curl_phi == 0))
		else $error("nonzero curl with zero divisor");

	// Loads never stall the port
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode_t'(mode) != MODE_QUERY) |=> !busy)
		else $error("load raised busy");

endmodule

bind cylindrical_curl_stencil_top ccs_checker u_ccs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.mode     (mode),
	.done     (done),
	.curl_r   (curl_r),
	.curl_z   (curl_z),
	.curl_phi (curl_phi),
	.status   (status)
);
